// ----- src/dte_pkg.sv -----
package dte_pkg;

    // field widths of the request and result items
    localparam int MODE_W  = 2;
    localparam int INDEX_W = 10;
    localparam int CHILD_W = 11;
    localparam int DIM_W   = 6;
    localparam int VALUE_W = 8;
    localparam int LEAF_W  = 10;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 11;
    localparam int MASK_W  = 64;

    // request kinds
    localparam logic [MODE_W-1:0] MODE_NODE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FEAT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EVAL = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_CHILD = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_DIM   = 2'd2;
    localparam logic [STAT_W-1:0] STATUS_STEP  = 2'd3;

    // configuration register indexes
    localparam logic CFG_ORDERED_MASK = 1'b0;
    localparam logic CFG_NODE_COUNT   = 1'b1;

    // one node table entry
    typedef struct packed {
        logic signed [CHILD_W-1:0] lo;
        logic signed [CHILD_W-1:0] hi;
        logic [DIM_W-1:0]          dim;
        logic [VALUE_W-1:0]        val;
    } dte_node_t;

    localparam int NODE_W = $bits(dte_node_t);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_WALK
    } dte_state_t;

endpackage

// ----- src/dte_ram.sv -----
module dte_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- src/decision_tree_evaluator_top.sv -----
// decision tree evaluator
//
// s_* channel takes requests: tuser holds the kind (write node, write feature,
// evaluate), tdata the node fields, the index and the feature byte. m_* channel
// returns one result per request: tdata holds the leaf, tuser the status.
// cfg_* channel writes ordered_mask (index 0) and node_count (index 1); it is
// always ready and may only be written while no request is in flight.
//
// a write request returns its result in the output register in the cycle
// after it is taken, so writes flow at one per cycle while the receiver keeps
// up. an evaluation reads the node table once per visited node, one
// synchronous read per cycle, and the block takes no new request until the
// walk's result is in the output register. the single node memory read port
// sets this pace.
//
// reset clears the feature bytes, sets ordered_mask to 0 and node_count to 1
// and empties the output register; the node table is not cleared. when the
// receiver stalls, the finished result waits in the output register and the
// block takes no further request until that register can be refilled.
module decision_tree_evaluator_top #(
    parameter int MAX_NODES     = 1024,
    parameter int FEATURE_COUNT = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,

    // request channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [9:0] index, [20:10] left_child, [31:21] right_child, [37:32] split_dim,
    // [45:38] split_value, [53:46] feature_value, [55:54] zero
    input  logic [55:0]                   s_tdata,
    // [1:0] mode
    input  logic [dte_pkg::MODE_W-1:0]    s_tuser,

    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [9:0] leaf, [15:10] zero
    output logic [15:0]                   m_tdata,
    // [1:0] status
    output logic [dte_pkg::STAT_W-1:0]    m_tuser,

    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [dte_pkg::MASK_W-1:0]    cfg_data
);

    import dte_pkg::*;

    localparam int NODE_AW = $clog2(MAX_NODES);
    localparam int FEAT_AW = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;

    // request fields
    logic [INDEX_W-1:0] req_index;
    dte_node_t          req_node;
    logic [VALUE_W-1:0] req_feat;

    assign req_index  = s_tdata[9:0];
    assign req_node.lo  = s_tdata[20:10];
    assign req_node.hi  = s_tdata[31:21];
    assign req_node.dim = s_tdata[37:32];
    assign req_node.val = s_tdata[45:38];
    assign req_feat   = s_tdata[53:46];

    // configuration
    logic [MASK_W-1:0]  ordered_mask_reg;
    logic [COUNT_W-1:0] node_count_reg;
    logic               cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ordered_mask_reg <= '0;
            node_count_reg   <= COUNT_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_ORDERED_MASK: ordered_mask_reg <= cfg_data;
                CFG_NODE_COUNT:   node_count_reg   <= cfg_data[COUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // node limit, clamped to 1..MAX_NODES
    logic [COUNT_W-1:0] count_eff;
    logic [COUNT_W-1:0] limit;

    assign count_eff = (node_count_reg == '0) ? COUNT_W'(1) : node_count_reg;
    assign limit     = ({21'b0, count_eff} > 32'(MAX_NODES)) ? COUNT_W'(MAX_NODES)
                                                             : count_eff;

    // control and output registers
    dte_state_t         state_reg, state_next;
    logic [COUNT_W-1:0] steps_reg, steps_next;
    logic               m_valid_reg, m_valid_next;
    logic [LEAF_W-1:0]  leaf_reg, leaf_next;
    logic [STAT_W-1:0]  status_reg, status_next;
    logic               out_free;
    logic               accept;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    // feature bytes
    logic [VALUE_W-1:0] feat_reg [FEATURE_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FEATURE_COUNT; i++)
            begin
                feat_reg[i] <= '0;
            end
        end
        else if (accept && s_tuser == MODE_FEAT &&
                 {22'b0, req_index} < 32'(FEATURE_COUNT))
        begin
            feat_reg[FEAT_AW'(req_index)] <= req_feat;
        end
    end

    // node table; a write lands before any later walk can read it
    logic               ram_we;
    logic               ram_re;
    logic [NODE_AW-1:0] ram_raddr;
    logic [NODE_W-1:0]  ram_rdata;
    dte_node_t          cur;

    assign ram_we = accept && s_tuser == MODE_NODE &&
                    {22'b0, req_index} < 32'(MAX_NODES);
    assign cur    = ram_rdata;

    dte_ram #(
        .WIDTH (NODE_W),
        .DEPTH (MAX_NODES)
    ) u_node_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (NODE_AW'({22'b0, req_index})),
        .wdata (req_node),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // one walk step on the node just read
    logic                      dim_bad;
    logic [FEAT_AW-1:0]        feat_idx;
    logic [VALUE_W-1:0]        feat_val;
    logic                      take;
    logic signed [CHILD_W-1:0] next_child;
    logic [CHILD_W-1:0]        next_inv;
    logic                      child_bad;
    logic                      steps_out;

    assign dim_bad    = {26'b0, cur.dim} >= 32'(FEATURE_COUNT);
    assign feat_idx   = dim_bad ? '0 : FEAT_AW'(cur.dim);
    assign feat_val   = feat_reg[feat_idx];
    assign take       = ordered_mask_reg[cur.dim] ? (feat_val >= cur.val)
                                                  : (feat_val == cur.val);
    assign next_child = take ? cur.hi : cur.lo;
    assign next_inv   = ~next_child;
    assign child_bad  = {1'b0, next_child[INDEX_W-1:0]} >= limit;
    assign steps_out  = steps_reg >= limit;

    always_comb
    begin
        state_next   = state_reg;
        steps_next   = steps_reg;
        m_valid_next = m_valid_reg && !m_tready;
        leaf_next    = leaf_reg;
        status_next  = status_reg;
        ram_re       = 1'b0;
        ram_raddr    = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == MODE_EVAL)
                    begin
                        // root read, never checked
                        ram_re     = 1'b1;
                        ram_raddr  = '0;
                        steps_next = COUNT_W'(1);
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        m_valid_next = 1'b1;
                        leaf_next    = '0;
                        status_next  = STATUS_OK;
                    end
                end
            end
            ST_WALK:
            begin
                if (!dim_bad && !next_child[CHILD_W-1] && !child_bad && !steps_out)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = NODE_AW'({22'b0, next_child[INDEX_W-1:0]});
                    steps_next = steps_reg + COUNT_W'(1);
                end
                else if (out_free)
                begin
                    m_valid_next = 1'b1;
                    leaf_next    = '0;
                    state_next   = ST_IDLE;
                    if (dim_bad)
                    begin
                        status_next = STATUS_DIM;
                    end
                    else if (next_child[CHILD_W-1])
                    begin
                        leaf_next   = next_inv[LEAF_W-1:0];
                        status_next = STATUS_OK;
                    end
                    else if (child_bad)
                    begin
                        status_next = STATUS_CHILD;
                    end
                    else
                    begin
                        status_next = STATUS_STEP;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            steps_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            steps_reg   <= steps_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        leaf_reg   <= leaf_next;
        status_reg <= status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, leaf_reg};
    assign m_tuser  = status_reg;

endmodule

// ----- bench/tb_decision_tree_evaluator_top.sv -----
module tb_decision_tree_evaluator_top;

    import dte_pkg::*;

    localparam int NODES    = 1024;
    localparam int FEATURES = 16;

    // the fourth request kind does nothing but return an empty result
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // expected result of one request
    typedef struct packed {
        logic [LEAF_W-1:0] leaf;
        logic [STAT_W-1:0] status;
    } leaf_result_t;

    // receiver stall patterns
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_BURSTY
    } rx_pattern_e;

    // mirror of the node table, feature bytes and registers; predicts the leaf
    // and status of every request and holds them until the result returns
    class tree_walk_scoreboard;
        dte_node_t         node_mem [NODES];
        bit                node_written [NODES];
        logic [7:0]        feature_mem [FEATURES];
        logic [MASK_W-1:0] ordered_mask;
        logic [COUNT_W-1:0] node_count;
        leaf_result_t      results_due [$];
        int                failures;
        int                checked;
        int                evaluations;
        int                status_seen [4];

        function new();
            foreach (node_written[i]) node_written[i] = 1'b0;
            foreach (feature_mem[i]) feature_mem[i] = 8'h00;
            foreach (status_seen[i]) status_seen[i] = 0;
            ordered_mask = '0;
            node_count   = 11'd1;
            failures     = 0;
            checked      = 0;
            evaluations  = 0;
        endfunction

        // node_count acts clamped to 1..NODES
        function int node_limit();
            if (node_count == 0)
                return 1;
            if (int'(node_count) > NODES)
                return NODES;
            return int'(node_count);
        endfunction

        function void apply_register(logic idx, logic [MASK_W-1:0] data);
            if (idx == CFG_ORDERED_MASK)
                ordered_mask = data;
            else
                node_count = data[COUNT_W-1:0];
        endfunction

        // walk from the root; missing gets the first never-written node on
        // the path, or -1 when the whole path was written
        function void walk_tree(output leaf_result_t res, output int missing);
            int                        lim;
            int                        node;
            int                        steps;
            bit                        done;
            bit                        take;
            dte_node_t                 cur;
            logic [7:0]                fval;
            logic signed [CHILD_W-1:0] next;
            lim     = node_limit();
            node    = 0;
            done    = 1'b0;
            missing = -1;
            res     = '{leaf: '0, status: STATUS_STEP};
            for (steps = 0; steps < lim && !done; steps++)
            begin
                if (!node_written[node])
                begin
                    missing = node;
                    done    = 1'b1;
                end
                else
                begin
                    cur = node_mem[node];
                    if (int'(cur.dim) >= FEATURES)
                    begin
                        res.status = STATUS_DIM;
                        done       = 1'b1;
                    end
                    else
                    begin
                        fval = feature_mem[cur.dim[3:0]];
                        // ordered dimension compares >=, the rest test equality
                        take = ordered_mask[cur.dim] ? (fval >= cur.val) : (fval == cur.val);
                        next = take ? cur.hi : cur.lo;
                        if (next < 0)
                        begin
                            res.leaf   = ~next[LEAF_W-1:0];
                            res.status = STATUS_OK;
                            done       = 1'b1;
                        end
                        else if (int'(next) >= lim)
                        begin
                            res.status = STATUS_CHILD;
                            done       = 1'b1;
                        end
                        else
                        begin
                            node = int'(next);
                        end
                    end
                end
            end
        endfunction

        function int first_missing_node();
            leaf_result_t res;
            int           missing;
            walk_tree(res, missing);
            return missing;
        endfunction

        function void note_request(logic [MODE_W-1:0] mode, logic [INDEX_W-1:0] idx,
                                   dte_node_t n, logic [7:0] fv);
            leaf_result_t res;
            int           missing;
            res = '0;
            case (mode)
                MODE_NODE:
                begin
                    node_mem[idx]     = n;
                    node_written[idx] = 1'b1;
                end
                MODE_FEAT:
                begin
                    if (int'(idx) < FEATURES)
                        feature_mem[idx[3:0]] = fv;
                end
                MODE_EVAL:
                begin
                    walk_tree(res, missing);
                    evaluations++;
                    status_seen[res.status]++;
                end
                default: ;
            endcase
            results_due.push_back(res);
        endfunction

        function void check_result(logic [LEAF_W-1:0] leaf, logic [STAT_W-1:0] status);
            leaf_result_t want;
            checked++;
            if (results_due.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("result %0d arrived with nothing pending: leaf %0d status %0d",
                             checked, leaf, status);
                return;
            end
            want = results_due.pop_front();
            if (leaf !== want.leaf || status !== want.status)
            begin
                failures++;
                if (failures <= 10)
                    $display("result %0d: expected leaf %0d status %0d, got leaf %0d status %0d",
                             checked, want.leaf, want.status, leaf, status);
            end
        endfunction

        function int pending();
            return results_due.size();
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [55:0]         s_tdata = '0;
    logic [MODE_W-1:0]   s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [15:0]         m_tdata;
    logic [STAT_W-1:0]   m_tuser;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic                cfg_index = 1'b0;
    logic [MASK_W-1:0]   cfg_data = '0;

    tree_walk_scoreboard sb;

    // sender burst state
    int burst_left;
    bit quiet;
    int requests_sent;
    int settings_done;

    // current walk bounds, used to keep random children mostly reachable
    int cur_limit;
    int cur_span;

    // receiver pattern state, owned by the receiver process
    rx_pattern_e rx_kind;
    int          rx_left;
    int          rx_hold;
    logic        rx_level;

    decision_tree_evaluator_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // result side: check each accepted result, then pick the next ready level
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata[LEAF_W-1:0], m_tuser);
        if (rx_left == 0)
        begin
            rx_kind = rx_pattern_e'($urandom_range(0, 3));
            rx_left = $urandom_range(50, 300);
        end
        else
        begin
            rx_left--;
        end
        case (rx_kind)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_tready <= (rx_left % 4 == 0);
            default:
            begin
                // alternating stretches of stall and accept
                if (rx_hold == 0)
                begin
                    rx_hold  = $urandom_range(1, 20);
                    rx_level = ~rx_level;
                end
                else
                begin
                    rx_hold--;
                end
                m_tready <= rx_level;
            end
        endcase
    end

    // hard stop in case the block hangs
    initial
    begin
        #40_000_000;
        $display("timeout: %0d results still pending", sb.pending());
        $display("Some tests failed");
        $finish;
    end

    function automatic dte_node_t make_node(int lo, int hi, int dim, int val);
        dte_node_t n;
        n.lo  = CHILD_W'(lo);
        n.hi  = CHILD_W'(hi);
        n.dim = DIM_W'(dim);
        n.val = VALUE_W'(val);
        return n;
    endfunction

    // corner bytes half the time so equality tests hit often
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 1) == 1)
            return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'h01;
            2:       return 8'h02;
            3:       return 8'h80;
            4:       return 8'hFE;
            default: return 8'hFF;
        endcase
    endfunction

    // leaf, forward node (tree shape), any node (may loop), or out of range
    function automatic logic signed [CHILD_W-1:0] random_child(int idx);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return CHILD_W'(-int'($urandom_range(1, 1024)));
        if (pick < 70 && idx + 1 < cur_span)
            return CHILD_W'($urandom_range(idx + 1, cur_span - 1));
        if (pick < 85)
            return CHILD_W'($urandom_range(0, cur_span - 1));
        if (cur_limit < NODES)
            return CHILD_W'($urandom_range(cur_limit, NODES - 1));
        return CHILD_W'($urandom_range(0, NODES - 1));
    endfunction

    function automatic dte_node_t random_node(int idx);
        dte_node_t n;
        n.lo  = random_child(idx);
        n.hi  = random_child(idx);
        n.dim = ($urandom_range(0, 99) < 85) ? DIM_W'($urandom_range(0, FEATURES - 1))
                                              : DIM_W'($urandom_range(FEATURES, 63));
        n.val = pick_byte();
        return n;
    endfunction

    function automatic dte_node_t noise_node();
        dte_node_t n;
        n = NODE_W'({$urandom, $urandom});
        return n;
    endfunction

    // one request; tvalid stays high across back-to-back requests of a burst
    task automatic send_request(input logic [MODE_W-1:0] mode, input logic [INDEX_W-1:0] idx,
                                input dte_node_t n, input logic [7:0] fv);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = quiet ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        // [9:0] index, [20:10] lo, [31:21] hi, [37:32] dim, [45:38] value, [53:46] feature
        s_tdata  <= {2'b00, fv, n.val, n.dim, n.hi, n.lo, idx};
        do @(posedge clk); while (!s_tready);
        sb.note_request(mode, idx, n, fv);
        // ignored requests do not count toward the stimulus size
        if (!(mode == MODE_UNUSED || (mode == MODE_FEAT && int'(idx) >= FEATURES)))
            requests_sent++;
    endtask

    task automatic write_node(input int idx, input dte_node_t n);
        send_request(MODE_NODE, INDEX_W'(idx), n, 8'($urandom));
    endtask

    task automatic write_feature(input int idx, input logic [7:0] value);
        send_request(MODE_FEAT, INDEX_W'(idx), noise_node(), value);
    endtask

    task automatic send_unused();
        send_request(MODE_UNUSED, INDEX_W'($urandom), noise_node(), 8'($urandom));
    endtask

    // fill in any never-written node the walk would touch, then evaluate
    task automatic evaluate_sample();
        int missing;
        missing = sb.first_missing_node();
        while (missing >= 0)
        begin
            write_node(missing, random_node(missing));
            missing = sb.first_missing_node();
        end
        send_request(MODE_EVAL, INDEX_W'($urandom), noise_node(), 8'($urandom));
    endtask

    // register writes only once every result is back and the block is quiet
    task automatic set_register(input logic idx, input logic [MASK_W-1:0] data);
        s_tvalid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.apply_register(idx, data);
        settings_done++;
        cur_limit = sb.node_limit();
        cur_span  = (cur_limit <= 64) ? cur_limit : 48;
    endtask

    // one register setting: build a tree top-down, load features, then a random mix
    task automatic run_phase(input int count, input logic [MASK_W-1:0] mask, input int items);
        int first;
        int pick;
        int idx;
        set_register(CFG_NODE_COUNT, MASK_W'(count));
        set_register(CFG_ORDERED_MASK, mask);
        quiet = ($urandom_range(0, 3) == 0);
        first = requests_sent;
        for (idx = 0; idx < cur_span; idx++)
            write_node(idx, random_node(idx));
        for (idx = 0; idx < FEATURES; idx++)
            write_feature(idx, pick_byte());
        while (requests_sent - first < items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                evaluate_sample();
            end
            else if (pick < 70)
            begin
                idx = ($urandom_range(0, 4) != 0) ? $urandom_range(0, cur_span - 1)
                                                  : $urandom_range(0, NODES - 1);
                write_node(idx, random_node(idx));
            end
            else if (pick < 88)
            begin
                write_feature($urandom_range(0, FEATURES - 1), pick_byte());
            end
            else if (pick < 94)
            begin
                send_unused();
            end
            else
            begin
                // out-of-range feature index, dropped by the block
                write_feature($urandom_range(FEATURES, NODES - 1), pick_byte());
            end
        end
    endtask

    initial
    begin
        sb            = new();
        burst_left    = 0;
        quiet         = 1'b0;
        requests_sent = 0;
        settings_done = 0;
        cur_limit     = 1;
        cur_span      = 1;
        rx_kind       = RX_OPEN;
        rx_left       = 0;
        rx_hold       = 0;
        rx_level      = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset registers, equality tests, count of one
        write_feature(0, 8'hFF);
        write_feature(15, 8'h00);
        write_feature(16, 8'h5A);
        write_feature(1023, 8'hA5);
        send_unused();
        // 255 == 255 takes the true branch to the top leaf
        write_node(0, make_node(-1, -1024, 0, 255));
        evaluate_sample();
        // mismatch takes the false branch
        write_node(0, make_node(-2, -1024, 0, 254));
        evaluate_sample();
        // child 1 is beyond a one-node tree
        write_node(0, make_node(1, 1, 15, 7));
        evaluate_sample();
        // root points at itself: step limit after one read
        write_node(0, make_node(0, 0, 1, 0));
        evaluate_sample();
        // dimensions past the feature vector
        write_node(0, make_node(-1, -1, 16, 0));
        evaluate_sample();
        write_node(0, make_node(-1, -1, 63, 255));
        evaluate_sample();
        write_node(1023, make_node(1023, -1024, 63, 255));

        // all dimensions ordered, count of zero acts as one
        set_register(CFG_ORDERED_MASK, '1);
        set_register(CFG_NODE_COUNT, '0);
        write_node(0, make_node(-1, -3, 0, 128));
        evaluate_sample();

        // count above the table size clamps to the full table
        set_register(CFG_NODE_COUNT, MASK_W'(2047));
        write_node(0, make_node(1023, 1023, 15, 1));
        evaluate_sample();
        // 0 -> 1023 -> 0 ... loops until the full step budget is spent
        write_node(1023, make_node(-1, 0, 0, 0));
        evaluate_sample();

        // random phases across small, odd and full-size trees
        run_phase(8, {$urandom, $urandom}, 110);
        run_phase(1024, '1, 110);
        run_phase(33, '0, 120);
        run_phase(64, {$urandom, $urandom}, 130);
        run_phase(2, {$urandom, $urandom}, 90);
        run_phase(16, '1, 110);
        run_phase(1023, {$urandom, $urandom}, 80);
        run_phase(5, 64'h8000_0000_0000_0000, 100);

        // drain, then give a late extra result time to show up
        s_tvalid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("covered %0d requests under %0d register writes; %0d results checked",
                 requests_sent, settings_done, sb.checked);
        $display("walks ending ok %0d, bad child %0d, bad dimension %0d, step limit %0d",
                 sb.status_seen[STATUS_OK], sb.status_seen[STATUS_CHILD],
                 sb.status_seen[STATUS_DIM], sb.status_seen[STATUS_STEP]);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
